// ===== sv/biquad_bandpass_power_tracker_top_defines.svh =====
// assertion macros for the band-pass power tracker
// no dependencies; included by the top level
`ifndef BIQUAD_BANDPASS_POWER_TRACKER_TOP_DEFINES_SVH
`define BIQUAD_BANDPASS_POWER_TRACKER_TOP_DEFINES_SVH

// same-cycle implication
`define BBPT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bbpt_pkg.sv =====
// constants, control word type and microcode table of the band-pass power tracker
// no dependencies; imported by the top level, the checker and the testbench
package bbpt_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_FRAC_BITS = 30;

   localparam int COEF_W = 32;
   localparam int GAIN_W = 31;
   localparam int ENV_W  = 31;
   localparam int OUT_W  = 32;
   localparam int DATA_W = 32;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = PROD_W;

   localparam int CLAMP_EXP = 62;

   localparam int Q31_LSH = 33 - 2 * SAMPLE_BITS;
   localparam int LSH_AMT = (Q31_LSH >= 0) ? Q31_LSH : 0;
   localparam int RSH_AMT = (Q31_LSH < 0) ? -Q31_LSH : 1;

   localparam int CHANNELS = 2;
   localparam logic CH_LEFT  = 1'b0;
   localparam logic CH_RIGHT = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FEED_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_ONE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_TWO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_RATE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_RATE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_MODE  = 3'd5;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LAST  = 4'd10;

   localparam logic [2:0] MUL_NONE = 3'd0;
   localparam logic [2:0] MUL_P0   = 3'd1;
   localparam logic [2:0] MUL_P2   = 3'd2;
   localparam logic [2:0] MUL_P1   = 3'd3;
   localparam logic [2:0] MUL_SQ   = 3'd4;
   localparam logic [2:0] MUL_FAST = 3'd5;
   localparam logic [2:0] MUL_DISP = 3'd6;

   localparam logic [1:0] ACC_HOLD = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_SUB  = 2'd2;

   typedef struct packed {
      logic [2:0] mul_sel;
      logic [1:0] acc_op;
      logic       wr_y;
      logic       wr_pw;
      logic       wr_penv;
      logic       wr_denv;
      logic       branch;
   } ucode_type;

   // per-channel program
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      case (step)
         4'd0: begin
            w.mul_sel = MUL_P0;
         end
         4'd1: begin
            w.mul_sel = MUL_P2;
            w.acc_op  = ACC_LOAD;
         end
         4'd2: begin
            w.mul_sel = MUL_P1;
            w.acc_op  = ACC_SUB;
         end
         4'd3: begin
            w.acc_op = ACC_SUB;
         end
         4'd4: begin
            w.wr_y = 1'b1;
         end
         4'd5: begin
            w.mul_sel = MUL_SQ;
         end
         4'd6: begin
            w.wr_pw = 1'b1;
         end
         4'd7: begin
            w.mul_sel = MUL_FAST;
         end
         4'd8: begin
            w.mul_sel = MUL_DISP;
            w.wr_penv = 1'b1;
         end
         4'd9: begin
            w.wr_denv = 1'b1;
         end
         4'd10: begin
            w.branch = 1'b1;
         end
         default: begin
            w = '0;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== sv/biquad_bandpass_power_tracker_top.sv =====
// each request runs an 11-step microcode program per channel (left only in mono
// mode) on one shared 33x33 multiplier; a new request is taken while the last
// result waits
// reset: synchronous, clears sequencer, filter history and envelopes,
// registers return to defaults (stereo on)
// top level: microcoded biquad band-pass with fast and display power envelopes
// depends on bbpt_pkg and biquad_bandpass_power_tracker_top_defines.svh
`include "biquad_bandpass_power_tracker_top_defines.svh"

module biquad_bandpass_power_tracker_top
   import bbpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [DATA_W-1:0]             csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ENV_W-1:0]              rsp_left_power,
   output logic [ENV_W-1:0]              rsp_right_power,
   output logic [ENV_W-1:0]              rsp_left_display_power,
   output logic [ENV_W-1:0]              rsp_right_display_power
);

   localparam logic signed [ACC_W-1:0] ACC_HI =
      {{(ACC_W-CLAMP_EXP-1){1'b0}}, 1'b1, {CLAMP_EXP{1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_HI;
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] Y_MAX =
      {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 1;
   localparam logic signed [ACC_W-1:0] ENV_MAX_S =
      {{(ACC_W-ENV_W){1'b0}}, {ENV_W{1'b1}}};
   localparam logic [PROD_W-1:0] ENV_MAX_U = {{(PROD_W-ENV_W){1'b0}}, {ENV_W{1'b1}}};
   localparam logic [PROD_W-1:0] SQ_RND = {{(PROD_W-1){1'b0}}, 1'b1} << (RSH_AMT - 1);

   // registers
   logic [GAIN_W-1:0]        feed_gain_ff;
   logic signed [COEF_W-1:0] feedback_one_ff;
   logic [GAIN_W-1:0]        feedback_two_ff;
   logic [GAIN_W-1:0]        fast_rate_ff;
   logic [GAIN_W-1:0]        display_rate_ff;
   logic                     stereo_mode_ff;

   // sequencer
   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   logic              ch_ff;
   logic              rsp_valid_ff;
   ucode_type         uc;
   logic              slot_free;
   logic              emit;
   logic              to_right;

   // channel state
   logic signed [SAMPLE_BITS-1:0] x_ff   [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] xp1_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] xp2_ff [CHANNELS];
   logic signed [OUT_W-1:0]       yp1_ff [CHANNELS];
   logic signed [OUT_W-1:0]       yp2_ff [CHANNELS];
   logic [ENV_W-1:0]              penv_ff[CHANNELS];
   logic [ENV_W-1:0]              denv_ff[CHANNELS];

   // datapath
   logic signed [SAMPLE_BITS:0]   diff_x;
   logic signed [ENV_W:0]         diff_p;
   logic signed [ENV_W:0]         diff_d;
   logic signed [MUL_W-1:0]       mul_a;
   logic signed [MUL_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]      prod_in;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_in;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_clamped;
   logic signed [ACC_W-1:0]       acc_round;
   logic signed [OUT_W-1:0]       y_in;
   logic [PROD_W-1:0]             sq_u;
   logic [PROD_W-1:0]             sq_shl;
   logic [PROD_W-1:0]             sq_rnd;
   logic [ENV_W-1:0]              pw_in;
   logic [ENV_W-1:0]              pw_ff;
   logic [ENV_W-1:0]              env_sel;
   logic signed [ACC_W-1:0]       env_d;
   logic signed [ACC_W-1:0]       env_sum;
   logic [ENV_W-1:0]              env_in;
   logic [ENV_W-1:0]              rsp_left_power_ff;
   logic [ENV_W-1:0]              rsp_right_power_ff;
   logic [ENV_W-1:0]              rsp_left_display_ff;
   logic [ENV_W-1:0]              rsp_right_display_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_power          = rsp_left_power_ff;
   assign rsp_right_power         = rsp_right_power_ff;
   assign rsp_left_display_power  = rsp_left_display_ff;
   assign rsp_right_display_power = rsp_right_display_ff;

   assign uc        = ucode_rom(step_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign to_right  = busy_ff && uc.branch && (ch_ff == CH_LEFT) && stereo_mode_ff;
   assign emit      = busy_ff && uc.branch && !to_right && slot_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_gain_ff    <= '0;
         feedback_one_ff <= '0;
         feedback_two_ff <= '0;
         fast_rate_ff    <= '0;
         display_rate_ff <= '0;
         stereo_mode_ff  <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FEED_GAIN:    feed_gain_ff    <= csr_data[GAIN_W-1:0];
            CSR_FEEDBACK_ONE: feedback_one_ff <= csr_data[COEF_W-1:0];
            CSR_FEEDBACK_TWO: feedback_two_ff <= csr_data[GAIN_W-1:0];
            CSR_FAST_RATE:    fast_rate_ff    <= csr_data[GAIN_W-1:0];
            CSR_DISPLAY_RATE: display_rate_ff <= csr_data[GAIN_W-1:0];
            CSR_STEREO_MODE:  stereo_mode_ff  <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // operand select for the shared multiplier
   assign diff_x = {x_ff[ch_ff][SAMPLE_BITS-1], x_ff[ch_ff]}
                 - {xp2_ff[ch_ff][SAMPLE_BITS-1], xp2_ff[ch_ff]};
   assign diff_p = $signed({1'b0, pw_ff}) - $signed({1'b0, penv_ff[ch_ff]});
   assign diff_d = $signed({1'b0, pw_ff}) - $signed({1'b0, denv_ff[ch_ff]});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul_sel)
         MUL_P0: begin
            mul_a = {{(MUL_W-GAIN_W){1'b0}}, feed_gain_ff};
            mul_b = {{(MUL_W-SAMPLE_BITS-1){diff_x[SAMPLE_BITS]}}, diff_x};
         end
         MUL_P2: begin
            mul_a = {{(MUL_W-GAIN_W){1'b0}}, feedback_two_ff};
            mul_b = {{(MUL_W-OUT_W){yp2_ff[ch_ff][OUT_W-1]}}, yp2_ff[ch_ff]};
         end
         MUL_P1: begin
            mul_a = {{(MUL_W-COEF_W){feedback_one_ff[COEF_W-1]}}, feedback_one_ff};
            mul_b = {{(MUL_W-OUT_W){yp1_ff[ch_ff][OUT_W-1]}}, yp1_ff[ch_ff]};
         end
         MUL_SQ: begin
            mul_a = {{(MUL_W-OUT_W){yp1_ff[ch_ff][OUT_W-1]}}, yp1_ff[ch_ff]};
            mul_b = {{(MUL_W-OUT_W){yp1_ff[ch_ff][OUT_W-1]}}, yp1_ff[ch_ff]};
         end
         MUL_FAST: begin
            mul_a = {{(MUL_W-GAIN_W){1'b0}}, fast_rate_ff};
            mul_b = {{(MUL_W-ENV_W-1){diff_p[ENV_W]}}, diff_p};
         end
         MUL_DISP: begin
            mul_a = {{(MUL_W-GAIN_W){1'b0}}, display_rate_ff};
            mul_b = {{(MUL_W-ENV_W-1){diff_d[ENV_W]}}, diff_d};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      case (uc.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_SUB:  acc_in = acc_ff - prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   // filter output: clamp, round half up, saturate
   always_comb begin
      if (acc_ff > ACC_HI) begin
         acc_clamped = ACC_HI;
      end else if (acc_ff < ACC_LO) begin
         acc_clamped = ACC_LO;
      end else begin
         acc_clamped = acc_ff;
      end
      acc_round = (acc_clamped + HALF) >>> COEF_FRAC_BITS;
      if (acc_round > Y_MAX) begin
         y_in = Y_MAX[OUT_W-1:0];
      end else if (acc_round < Y_MIN) begin
         y_in = Y_MIN[OUT_W-1:0];
      end else begin
         y_in = acc_round[OUT_W-1:0];
      end
   end

   // square to q0.31
   always_comb begin
      sq_u   = prod_ff;
      sq_shl = sq_u << LSH_AMT;
      sq_rnd = (sq_u + SQ_RND) >> RSH_AMT;
      if (Q31_LSH >= 0) begin
         if (sq_u > (ENV_MAX_U >> LSH_AMT)) begin
            pw_in = ENV_MAX_U[ENV_W-1:0];
         end else begin
            pw_in = sq_shl[ENV_W-1:0];
         end
      end else begin
         if (sq_rnd > ENV_MAX_U) begin
            pw_in = ENV_MAX_U[ENV_W-1:0];
         end else begin
            pw_in = sq_rnd[ENV_W-1:0];
         end
      end
   end

   // shared envelope update
   always_comb begin
      env_sel = uc.wr_penv ? penv_ff[ch_ff] : denv_ff[ch_ff];
      env_d   = (prod_ff + HALF) >>> COEF_FRAC_BITS;
      env_sum = $signed({{(ACC_W-ENV_W){1'b0}}, env_sel}) + env_d;
      if (env_sum < 0) begin
         env_in = '0;
      end else if (env_sum > ENV_MAX_S) begin
         env_in = ENV_MAX_S[ENV_W-1:0];
      end else begin
         env_in = env_sum[ENV_W-1:0];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (busy_ff && uc.wr_pw) begin
         pw_ff <= pw_in;
      end
      if (req_valid && req_ready) begin
         x_ff[CH_LEFT]  <= req_left_sample;
         x_ff[CH_RIGHT] <= req_right_sample;
      end
      if (emit) begin
         rsp_left_power_ff   <= penv_ff[CH_LEFT];
         rsp_left_display_ff <= denv_ff[CH_LEFT];
         if (ch_ff == CH_LEFT) begin
            rsp_right_power_ff   <= penv_ff[CH_LEFT];
            rsp_right_display_ff <= denv_ff[CH_LEFT];
         end else begin
            rsp_right_power_ff   <= penv_ff[CH_RIGHT];
            rsp_right_display_ff <= denv_ff[CH_RIGHT];
         end
      end
   end

   // sequencer and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_FIRST;
         ch_ff        <= CH_LEFT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            xp1_ff[i]  <= '0;
            xp2_ff[i]  <= '0;
            yp1_ff[i]  <= '0;
            yp2_ff[i]  <= '0;
            penv_ff[i] <= '0;
            denv_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready && !emit) begin
            rsp_valid_ff <= 1'b0;
         end
         if (!busy_ff) begin
            if (req_valid) begin
               busy_ff <= 1'b1;
               step_ff <= STEP_FIRST;
               ch_ff   <= CH_LEFT;
            end
         end else if (uc.branch) begin
            if (to_right) begin
               ch_ff   <= CH_RIGHT;
               step_ff <= STEP_FIRST;
            end else if (emit) begin
               busy_ff      <= 1'b0;
               step_ff      <= STEP_FIRST;
               ch_ff        <= CH_LEFT;
               rsp_valid_ff <= 1'b1;
               if (ch_ff == CH_LEFT) begin
                  penv_ff[CH_RIGHT] <= penv_ff[CH_LEFT];
                  denv_ff[CH_RIGHT] <= denv_ff[CH_LEFT];
               end
            end
         end else begin
            step_ff <= step_ff + 1'b1;
         end
         if (busy_ff && uc.wr_y) begin
            xp2_ff[ch_ff] <= xp1_ff[ch_ff];
            xp1_ff[ch_ff] <= x_ff[ch_ff];
            yp2_ff[ch_ff] <= yp1_ff[ch_ff];
            yp1_ff[ch_ff] <= y_in;
         end
         if (busy_ff && uc.wr_penv) begin
            penv_ff[ch_ff] <= env_in;
         end
         if (busy_ff && uc.wr_denv) begin
            denv_ff[ch_ff] <= env_in;
         end
      end
   end

   `BBPT_ASSERT_SAME(a_idle_at_start, clock, reset, !busy_ff, step_ff == STEP_FIRST && ch_ff == CH_LEFT, "idle sequencer not parked at first step")
   `BBPT_ASSERT_SAME(a_step_in_program, clock, reset, busy_ff, step_ff <= STEP_LAST, "step counter past end of program")
   `BBPT_ASSERT_NEXT(a_request_starts_run, clock, reset, req_valid && req_ready, busy_ff, "accepted request did not start the sequencer")
   `BBPT_ASSERT_SAME(a_response_ends_run, clock, reset, $rose(rsp_valid_ff), $past(busy_ff) && !busy_ff, "response raised outside end of run")

endmodule

// ===== sim/power_tracker_checker.sv =====
// checker for the band-pass power tracker: follows register writes and requests,
// predicts the four power envelopes per request and compares them with each response
// depends on bbpt_pkg
module power_tracker_checker
   import bbpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [DATA_W-1:0]             csr_data,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [ENV_W-1:0]              rsp_left_power,
   input  logic [ENV_W-1:0]              rsp_right_power,
   input  logic [ENV_W-1:0]              rsp_left_display_power,
   input  logic [ENV_W-1:0]              rsp_right_display_power,
   output int                            pending,
   output int                            failures
);

   localparam int WIDE = 80;
   localparam logic signed [WIDE-1:0] CLAMP_LIM = 80'sh4000_0000_0000_0000;
   localparam logic signed [WIDE-1:0] HALF_LSB  = 80'sd1 <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [WIDE-1:0] Y_MAX     = 80'sh7FFF_FFFF;
   localparam logic signed [WIDE-1:0] Y_MIN     = -80'sh8000_0000;
   localparam logic signed [WIDE-1:0] ENV_MAX   = 80'sh7FFF_FFFF;
   localparam logic signed [WIDE-1:0] SQ_LIMIT  = ENV_MAX >>> LSH_AMT;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] in_prev;
      logic signed [SAMPLE_BITS-1:0] in_prev2;
      logic signed [OUT_W-1:0]       out_prev;
      logic signed [OUT_W-1:0]       out_prev2;
      logic [ENV_W-1:0]              fast_env;
      logic [ENV_W-1:0]              disp_env;
   } band_state_type;

   typedef struct packed {
      logic [ENV_W-1:0] left_fast;
      logic [ENV_W-1:0] right_fast;
      logic [ENV_W-1:0] left_disp;
      logic [ENV_W-1:0] right_disp;
   } power_set_type;

   logic [GAIN_W-1:0]        cfg_gain;
   logic signed [COEF_W-1:0] cfg_fb1;
   logic [GAIN_W-1:0]        cfg_fb2;
   logic [ENV_W-1:0]         cfg_fast;
   logic [ENV_W-1:0]         cfg_disp;
   logic                     cfg_stereo;

   band_state_type left_band;
   band_state_type right_band;
   power_set_type  expected_powers[$];
   int             mismatches = 0;
   int             results_seen = 0;

   function automatic logic signed [WIDE-1:0] as_wide(input logic [ENV_W-1:0] u);
      return $signed({{(WIDE - ENV_W){1'b0}}, u});
   endfunction

   // clamp to +-2^62, then round half up to the coefficient point
   function automatic logic signed [WIDE-1:0] round_q30(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] c;
      c = (v > CLAMP_LIM) ? CLAMP_LIM : ((v < -CLAMP_LIM) ? -CLAMP_LIM : v);
      return (c + HALF_LSB) >>> COEF_FRAC_BITS;
   endfunction

   function automatic logic [ENV_W-1:0] power_q31(input logic signed [OUT_W-1:0] y);
      logic signed [WIDE-1:0] mag;
      logic signed [WIDE-1:0] sq;
      mag = y;
      if (mag < 0) mag = -mag;
      sq = mag * mag;
      if (sq > SQ_LIMIT) return ENV_MAX[ENV_W-1:0];
      sq = sq <<< LSH_AMT;
      return sq[ENV_W-1:0];
   endfunction

   function automatic logic [ENV_W-1:0] env_step(input logic [ENV_W-1:0] env,
                                                 input logic [ENV_W-1:0] pw,
                                                 input logic [ENV_W-1:0] rate);
      logic signed [WIDE-1:0] nxt;
      nxt = as_wide(env) + round_q30((as_wide(pw) - as_wide(env)) * as_wide(rate));
      if (nxt < 0) nxt = 0;
      if (nxt > ENV_MAX) nxt = ENV_MAX;
      return nxt[ENV_W-1:0];
   endfunction

   function automatic band_state_type advance_band(input band_state_type c,
                                                   input logic signed [SAMPLE_BITS-1:0] x);
      logic signed [WIDE-1:0] xw, x2w, y1w, y2w, fb1w, acc, y;
      logic [ENV_W-1:0]       pw;
      band_state_type         n;
      xw   = x;
      x2w  = c.in_prev2;
      y1w  = c.out_prev;
      y2w  = c.out_prev2;
      fb1w = cfg_fb1;
      acc  = as_wide(cfg_gain) * (xw - x2w) - as_wide(cfg_fb2) * y2w - fb1w * y1w;
      y    = round_q30(acc);
      if (y > Y_MAX) y = Y_MAX;
      if (y < Y_MIN) y = Y_MIN;
      n = c;
      n.in_prev2  = c.in_prev;
      n.in_prev   = x;
      n.out_prev2 = c.out_prev;
      n.out_prev  = y[OUT_W-1:0];
      pw = power_q31(y[OUT_W-1:0]);
      n.fast_env = env_step(c.fast_env, pw, cfg_fast);
      n.disp_env = env_step(c.disp_env, pw, cfg_disp);
      return n;
   endfunction

   always @(posedge clock) begin : monitor
      power_set_type got;
      power_set_type want;
      if (reset) begin
         cfg_gain   = '0;
         cfg_fb1    = '0;
         cfg_fb2    = '0;
         cfg_fast   = '0;
         cfg_disp   = '0;
         cfg_stereo = 1'b1;
         left_band  = '{default: '0};
         right_band = '{default: '0};
         expected_powers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FEED_GAIN:    cfg_gain   = csr_data[GAIN_W-1:0];
               CSR_FEEDBACK_ONE: cfg_fb1    = csr_data[COEF_W-1:0];
               CSR_FEEDBACK_TWO: cfg_fb2    = csr_data[GAIN_W-1:0];
               CSR_FAST_RATE:    cfg_fast   = csr_data[ENV_W-1:0];
               CSR_DISPLAY_RATE: cfg_disp   = csr_data[ENV_W-1:0];
               CSR_STEREO_MODE:  cfg_stereo = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_left_power, rsp_right_power,
                   rsp_left_display_power, rsp_right_display_power};
            results_seen++;
            if (expected_powers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with no request outstanding: %h %h %h %h",
                           results_seen, got.left_fast, got.right_fast,
                           got.left_disp, got.right_disp);
            end else begin
               want = expected_powers.pop_front();
               if (got.left_fast != want.left_fast || got.right_fast != want.right_fast ||
                   got.left_disp != want.left_disp || got.right_disp != want.right_disp) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d: expected fast %h/%h display %h/%h",
                              results_seen, want.left_fast, want.right_fast,
                              want.left_disp, want.right_disp);
                     $display("result %0d: actual   fast %h/%h display %h/%h",
                              results_seen, got.left_fast, got.right_fast,
                              got.left_disp, got.right_disp);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            left_band = advance_band(left_band, req_left_sample);
            if (cfg_stereo) begin
               right_band = advance_band(right_band, req_right_sample);
            end else begin
               right_band.fast_env = left_band.fast_env;
               right_band.disp_env = left_band.disp_env;
            end
            expected_powers.push_back({left_band.fast_env, right_band.fast_env,
                                       left_band.disp_env, right_band.disp_env});
         end
      end
      pending  <= expected_powers.size();
      failures <= mismatches;
   end

endmodule

// ===== sim/tb.sv =====
// testbench top for the band-pass power tracker: clock, reset, register writes,
// sample requests and response stalls; the verdict comes from power_tracker_checker
// depends on bbpt_pkg, biquad_bandpass_power_tracker_top and power_tracker_checker
module tb;
   import bbpt_pkg::*;

   localparam int WAIT_MAX        = 11;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 25;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 165;
   localparam int HOLD_OFF_PHASE  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam logic [DATA_W-1:0]    Q30_ONE     = 32'h4000_0000;

   localparam logic signed [SAMPLE_BITS-1:0] EDGE_SAMPLES [8] = '{
      16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
      16'sh0001, 16'sh7FFF, 16'sh7FFF, 16'sh8000
   };

   logic                          clock;
   logic                          reset;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [DATA_W-1:0]             csr_data;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_left_sample;
   logic signed [SAMPLE_BITS-1:0] req_right_sample;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [ENV_W-1:0]              rsp_left_power;
   logic [ENV_W-1:0]              rsp_right_power;
   logic [ENV_W-1:0]              rsp_left_display_power;
   logic [ENV_W-1:0]              rsp_right_display_power;

   int pending;
   int failures;
   int n_sent = 0;
   int n_settings = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   bit hold_off_ask = 1'b0;

   biquad_bandpass_power_tracker_top u_top (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_left_sample         (req_left_sample),
      .req_right_sample        (req_right_sample),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_left_power          (rsp_left_power),
      .rsp_right_power         (rsp_right_power),
      .rsp_left_display_power  (rsp_left_display_power),
      .rsp_right_display_power (rsp_right_display_power)
   );

   power_tracker_checker u_check (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_left_sample         (req_left_sample),
      .req_right_sample        (req_right_sample),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_left_power          (rsp_left_power),
      .rsp_right_power         (rsp_right_power),
      .rsp_left_display_power  (rsp_left_display_power),
      .rsp_right_display_power (rsp_right_display_power),
      .pending                 (pending),
      .failures                (failures)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int          sel;
      logic [31:0] raw;
      sel = $urandom_range(0, 19);
      raw = $urandom();
      if (sel == 0) return {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      if (sel == 1) return {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      if (sel < 5) return SAMPLE_BITS'($signed(raw[7:0]));
      return raw[SAMPLE_BITS-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] pick_corner();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return Q30_ONE;
         2: return 32'h7FFF_FFFF;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [DATA_W-1:0] gain, fb1, fb2, fast, disp, mode,
                                 input bit poke_spare);
      write_reg(CSR_FEED_GAIN, gain);
      write_reg(CSR_FEEDBACK_ONE, fb1);
      write_reg(CSR_FEEDBACK_TWO, fb2);
      write_reg(CSR_FAST_RATE, fast);
      write_reg(CSR_DISPLAY_RATE, disp);
      write_reg(CSR_STEREO_MODE, mode);
      if (poke_spare) begin
         write_reg(CSR_SPARE_A, $urandom());
         write_reg(CSR_SPARE_B, $urandom());
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic random_settings(input int kind, input bit stereo);
      logic [DATA_W-1:0] gain, fb1, fb2, fast, disp, mag, mode;
      mode = {31'($urandom()), stereo};
      case (kind)
         0: begin
            // stable resonator inside the stability triangle
            fb2  = $urandom_range(32'h3800_0000, 32'h3FFF_FFFF);
            mag  = $urandom_range(0, Q30_ONE + fb2 - 32'h0010_0000);
            fb1  = $urandom_range(0, 1) ? -mag : mag;
            gain = $urandom_range(0, 32'h0800_0000);
            fast = $urandom_range(32'h0010_0000, Q30_ONE);
            disp = $urandom_range(0, 32'h0040_0000);
            apply_settings(gain, fb1, fb2, fast, disp, mode, 1'b0);
         end
         1: begin
            apply_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           mode, 1'b1);
         end
         default: begin
            fb1 = $urandom_range(0, 1) ? 32'h8000_0000 : pick_corner();
            apply_settings(pick_corner(), fb1, pick_corner(), pick_corner(), pick_corner(),
                           mode, 1'b0);
         end
      endcase
   endtask

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] left_in, right_in);
      int gap;
      gap = draw_wait(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= left_in;
      req_right_sample <= right_in;
      do @(posedge clock); while (!req_ready);
      n_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // response side: random stalls, and one long hold-off on request
   initial begin : sink
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = draw_wait(rsp_quiet);
         if (hold_off_ask) begin
            hold_off_ask = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("no channel moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = CSR_FEED_GAIN;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_left_sample  = '0;
      req_right_sample = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: zero coefficients, stereo
      repeat (4) send_sample(pick_sample(), pick_sample());
      drain();

      // unity gain, no feedback, power saturation
      apply_settings(Q30_ONE, '0, '0, Q30_ONE, 32'h0400_0000, 32'd1, 1'b0);
      for (int i = 0; i < 8; i++) send_sample(EDGE_SAMPLES[i], EDGE_SAMPLES[7 - i]);
      drain();

      // filter overflow, mono, rate near 2, upper register bits set
      apply_settings(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0,
                     32'hFFFF_FFFE, 1'b1);
      for (int i = 0; i < 8; i++) send_sample(EDGE_SAMPLES[i], EDGE_SAMPLES[i]);
      drain();

      // envelope overshoot both ways, stereo with upper bits set
      apply_settings(Q30_ONE, 32'h7FFF_FFFF, '0, 32'h6000_0000, 32'd1, 32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < 5; i++) send_sample(EDGE_SAMPLES[i + 3], EDGE_SAMPLES[i]);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         random_settings(ph % 3, ph[0]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == HOLD_OFF_PHASE && k == 40) hold_off_ask = 1'b1;
            send_sample(pick_sample(), pick_sample());
         end
         drain();
      end

      $display("run covered %0d requests over %0d register settings, mono and stereo,",
               n_sent, n_settings);
      $display("with saturating and stable filters, random stalls and one long output hold-off");
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/bbpt_pkg.sv
sv/biquad_bandpass_power_tracker_top.sv
sim/power_tracker_checker.sv
sim/tb.sv
